[rtl/vtm_pkg.sv]
package vtm_pkg;

    localparam int TIMERS = 8;
    localparam int IDX_W = $clog2(TIMERS) > 0 ? $clog2(TIMERS) : 1;
    localparam int CNT_W = $clog2(TIMERS + 1);
    localparam int TICK_W = 48;
    localparam logic [TICK_W-1:0] TICK_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] KIND_SET    = 3'd0;
    localparam logic [2:0] KIND_CHANGE = 3'd1;
    localparam logic [2:0] KIND_START  = 3'd2;
    localparam logic [2:0] KIND_STOP   = 3'd3;
    localparam logic [2:0] KIND_MATCH  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_RESERVED = 2'd3;

    localparam logic [0:0] ADDR_LIMIT = 1'b0;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        tmr_id;
        logic [31:0]       delay_ticks;
        logic [31:0]       period_ticks;
        logic              one_shot;
        logic              lock_flag;
        logic [TICK_W-1:0] now;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              compare_valid;
        logic [TICK_W-1:0] compare_value;
        logic              fired;
        logic [7:0]        fired_timer_id;
        logic              fired_deferred;
    } rsp_t;

    // one timer entry as it travels round the ring
    typedef struct packed {
        logic [7:0]        id;
        logic [31:0]       period;
        logic [31:0]       delay;
        logic [TICK_W-1:0] match;
        logic              run;
        logic              res;
        logic              one;
    } entry_t;

    // per-cycle command from the sequencer to every cell
    typedef struct packed {
        logic   shift;
        logic   write;
        entry_t wdata;
    } ring_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_SEARCH,
        S_OUT
    } state_t;

endpackage

[rtl/vtm_cell.sv]
module vtm_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  vtm_pkg::ring_ctl_t  ctl,
    input  logic                head,
    input  vtm_pkg::entry_t     din,
    output vtm_pkg::entry_t     dout
);

    vtm_pkg::entry_t            ent_cur;
    vtm_pkg::entry_t            ent_next;
    logic [7:0]                 id_reg;
    logic                       run_reg;
    logic                       res_reg;
    logic                       one_reg;
    logic [31:0]                period_reg;
    logic [31:0]                delay_reg;
    logic [vtm_pkg::TICK_W-1:0] match_reg;

    assign ent_cur = {id_reg, period_reg, delay_reg, match_reg, run_reg, res_reg, one_reg};

    // the head cell takes a rewritten entry instead of its neighbor's
    always_comb
    begin
        ent_next = ent_cur;
        if (ctl.shift)
        begin
            ent_next = (head && ctl.write) ? ctl.wdata : din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg  <= '0;
            run_reg <= 1'b0;
            res_reg <= 1'b0;
            one_reg <= 1'b0;
        end
        else
        begin
            id_reg  <= ent_next.id;
            run_reg <= ent_next.run;
            res_reg <= ent_next.res;
            one_reg <= ent_next.one;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg <= ent_next.period;
        delay_reg  <= ent_next.delay;
        match_reg  <= ent_next.match;
    end

    assign dout = ent_cur;

endmodule

[rtl/vtm_ring.sv]
module vtm_ring (
    input  logic                clk,
    input  logic                rst_n,
    input  vtm_pkg::ring_ctl_t  ctl,
    output vtm_pkg::entry_t     tail
);

    vtm_pkg::entry_t link [vtm_pkg::TIMERS];

    // cell 0 is the head; the last cell feeds back into it
    for (genvar g = 0; g < vtm_pkg::TIMERS; g++)
    begin : g_cell
        vtm_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .ctl  (ctl),
            .head (g == 0),
            .din  (link[(g + vtm_pkg::TIMERS - 1) % vtm_pkg::TIMERS]),
            .dout (link[g])
        );
    end

    assign tail = link[vtm_pkg::TIMERS-1];

endmodule

[rtl/virtual_timer_multiplexer_top.sv]
// Virtual timer multiplexer. The timer table is a ring of TIMERS cells that
// rotates one position per cycle during the scan, apply and search phases; the
// entry leaving the last cell is the one the sequencer examines and may rewrite
// as it re-enters the first cell. A request passes through a lap for the id
// lookup and a lap to apply the change, and for start and match a further lap
// for the earliest-match search, before its response is registered.
// One request is in flight at a time; the response sits in an output register
// and the next request is taken once it has been handed over.
module virtual_timer_multiplexer_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  vtm_pkg::req_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output vtm_pkg::rsp_t   out_data,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int IW = vtm_pkg::IDX_W;
    localparam int CW = vtm_pkg::CNT_W;
    localparam logic [CW-1:0] LAST = CW'(vtm_pkg::TIMERS - 1);
    localparam logic [CW-1:0] FULL = CW'(vtm_pkg::TIMERS);

    logic [7:0]         limit_reg;
    vtm_pkg::state_t    state_reg, state_next;
    vtm_pkg::req_t      req_reg;
    logic [CW-1:0]      step_reg, step_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      cur_reg, cur_next;
    logic               found_reg, found_next;
    logic [IW-1:0]      slot_reg, slot_next;
    logic               any_reg, any_next;
    logic [IW-1:0]      pick_reg, pick_next;
    logic [47:0]        best_reg, best_next;
    logic               out_valid_reg;
    vtm_pkg::rsp_t      rsp_reg, rsp_next;
    vtm_pkg::ring_ctl_t ctl;
    vtm_pkg::entry_t    tail;
    logic               apb_wr;
    logic [IW-1:0]      pos;
    logic               in_use;
    logic               search;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == vtm_pkg::ADDR_LIMIT) ? {24'd0, limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= '0;
        else if (apb_wr && paddr[2] == vtm_pkg::ADDR_LIMIT)
            limit_reg <= pwdata[7:0];
    end

    vtm_ring u_ring (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .tail (tail)
    );

    // a new request may enter in the cycle the previous response is taken
    assign in_ready  = (state_reg == vtm_pkg::S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;
    assign pos       = step_reg[IW-1:0];
    assign in_use    = step_reg < count_reg;
    assign search    = req_reg.kind == vtm_pkg::KIND_START || req_reg.kind == vtm_pkg::KIND_MATCH;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vtm_pkg::S_IDLE:
                if (in_valid && in_ready)
                    state_next = vtm_pkg::S_SCAN;
            vtm_pkg::S_SCAN:
                if (step_reg == LAST)
                    state_next = vtm_pkg::S_APPLY;
            vtm_pkg::S_APPLY:
                if (step_reg == LAST)
                    state_next = search ? vtm_pkg::S_SEARCH : vtm_pkg::S_OUT;
            vtm_pkg::S_SEARCH:
                if (step_reg == LAST)
                    state_next = vtm_pkg::S_OUT;
            vtm_pkg::S_OUT:
                if (!out_valid_reg || out_ready)
                    state_next = vtm_pkg::S_IDLE;
            default:
                state_next = vtm_pkg::S_IDLE;
        endcase
    end

    // datapath and ring control
    always_comb
    begin
        logic hit;
        logic [47:0] sum;
        vtm_pkg::entry_t w;
        logic tgt;
        hit        = 1'b0;
        sum        = '0;
        w          = tail;
        tgt        = 1'b0;
        step_next  = step_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        found_next = found_reg;
        slot_next  = slot_reg;
        any_next   = any_reg;
        pick_next  = pick_reg;
        best_next  = best_reg;
        rsp_next   = rsp_reg;
        ctl        = '0;
        unique case (state_reg)
            vtm_pkg::S_IDLE:
            begin
                step_next  = '0;
                found_next = 1'b0;
                slot_next  = '0;
                any_next   = 1'b0;
                pick_next  = '0;
                best_next  = vtm_pkg::TICK_MAX;
                rsp_next   = '0;
            end
            vtm_pkg::S_SCAN:
            begin
                // tail holds entry at position step_reg
                ctl.shift = 1'b1;
                hit = in_use && tail.id == req_reg.tmr_id && !found_reg;
                if (hit)
                begin
                    found_next = 1'b1;
                    slot_next  = pos;
                end
                step_next = (step_reg == LAST) ? '0 : step_reg + 1'b1;
                if (step_reg == LAST)
                begin
                    // resolve status and the slot to touch
                    priority case (req_reg.kind)
                        vtm_pkg::KIND_SET:
                            if (!(found_reg || hit))
                            begin
                                if (count_reg >= FULL)
                                    rsp_next.status = vtm_pkg::ST_FULL;
                                else
                                begin
                                    slot_next  = count_reg[IW-1:0];
                                    found_next = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        vtm_pkg::KIND_CHANGE, vtm_pkg::KIND_START, vtm_pkg::KIND_STOP:
                            if (!(found_reg || hit))
                                rsp_next.status = vtm_pkg::ST_NOT_FOUND;
                        vtm_pkg::KIND_MATCH:
                        begin
                            found_next = 1'b1;
                            slot_next  = cur_reg;
                        end
                        default:
                            found_next = 1'b0;
                    endcase
                end
            end
            vtm_pkg::S_APPLY:
            begin
                ctl.shift = 1'b1;
                ctl.write = 1'b1;
                tgt = found_reg && pos == slot_reg;
                if (tgt)
                begin
                    unique case (req_reg.kind)
                        vtm_pkg::KIND_SET:
                            if (tail.res)
                                rsp_next.status = vtm_pkg::ST_RESERVED;
                            else
                            begin
                                w.period = req_reg.period_ticks;
                                w.delay  = req_reg.delay_ticks;
                                w.id     = req_reg.tmr_id;
                                w.one    = req_reg.one_shot;
                                w.res    = req_reg.lock_flag;
                                w.run    = 1'b0;
                                w.match  = req_reg.now + 48'(req_reg.period_ticks)
                                    + 48'(req_reg.delay_ticks);
                            end
                        vtm_pkg::KIND_CHANGE:
                        begin
                            w.period = req_reg.period_ticks;
                            w.delay  = req_reg.delay_ticks;
                            w.one    = req_reg.one_shot;
                        end
                        vtm_pkg::KIND_START:
                            if (!tail.run)
                            begin
                                w.match = req_reg.now + 48'(tail.period) + 48'(tail.delay);
                                w.run   = 1'b1;
                                any_next = 1'b1;
                            end
                        vtm_pkg::KIND_STOP:
                        begin
                            w.run = 1'b0;
                            w.res = 1'b0;
                        end
                        vtm_pkg::KIND_MATCH:
                        begin
                            if (tail.run)
                            begin
                                rsp_next.fired          = 1'b1;
                                rsp_next.fired_timer_id = tail.id;
                                rsp_next.fired_deferred = tail.id > limit_reg;
                            end
                            if (tail.one)
                                w.run = 1'b0;
                            else
                                w.match = req_reg.now + 48'(tail.period);
                            any_next = 1'b1;
                        end
                        default:
                            w = tail;
                    endcase
                end
                ctl.wdata = w;
                step_next = (step_reg == LAST) ? '0 : step_reg + 1'b1;
            end
            vtm_pkg::S_SEARCH:
            begin
                // any_reg marks that the search counts for this request
                ctl.shift = 1'b1;
                sum = tail.match;
                if (in_use && tail.run && sum <= best_reg)
                begin
                    best_next = sum;
                    pick_next = pos;
                    found_next = 1'b0;
                    rsp_next.compare_valid = any_reg;
                end
                step_next = (step_reg == LAST) ? '0 : step_reg + 1'b1;
                if (step_reg == LAST && rsp_next.compare_valid)
                begin
                    rsp_next.compare_value = (best_next < req_reg.now) ? req_reg.now : best_next;
                    cur_next = pick_next;
                end
            end
            vtm_pkg::S_OUT:
                step_next = '0;
            default:
                step_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vtm_pkg::S_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            cur_reg       <= '0;
            found_reg     <= 1'b0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
            found_reg <= found_next;
            any_reg   <= any_next;
            if (state_reg == vtm_pkg::S_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            req_reg <= in_data;
        slot_reg <= slot_next;
        pick_reg <= pick_next;
        best_reg <= best_next;
        if (state_reg != vtm_pkg::S_OUT && (!out_valid_reg || out_ready))
            rsp_reg <= rsp_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL) else $error("entry count overflow");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("response dropped");

    a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vtm_pkg::S_IDLE |-> step_reg == '0 || $past(state_reg) == vtm_pkg::S_OUT)
        else $error("ring not aligned");

endmodule
